/* rtl/scl_pkg.sv */
// Package for the source code lexer: token kinds, lexer modes and the
// record passed from the classifier to the token queue. No dependencies.
package scl_pkg;

  localparam int KIND_BITS = 6;
  localparam int OUT_BITS = 32;

  localparam logic [5:0] K_SQLIT = 6'd51;
  localparam logic [5:0] K_DQLIT = 6'd52;
  localparam logic [5:0] K_IDENT = 6'd53;
  localparam logic [5:0] K_NUM = 6'd54;
  localparam logic [5:0] K_END = 6'd55;
  localparam logic [5:0] K_LINE = 6'd56;
  localparam logic [5:0] K_UNKNOWN = 6'd57;
  localparam logic [5:0] K_UNTERM_LIT = 6'd58;
  localparam logic [5:0] K_UNTERM_COMMENT = 6'd59;

  // Lexer modes; pending operators occupy M_OP .. M_OP+15.
  localparam logic [4:0] M_IDLE = 5'd0;
  localparam logic [4:0] M_IDENT = 5'd1;
  localparam logic [4:0] M_NUM = 5'd2;
  localparam logic [4:0] M_SQ = 5'd3;
  localparam logic [4:0] M_SQ_ESC = 5'd4;
  localparam logic [4:0] M_DQ = 5'd5;
  localparam logic [4:0] M_DQ_ESC = 5'd6;
  localparam logic [4:0] M_LINE = 5'd7;
  localparam logic [4:0] M_BLOCK = 5'd8;
  localparam logic [4:0] M_BSTAR = 5'd9;
  localparam logic [4:0] M_BSLASH = 5'd10;
  localparam logic [4:0] M_OP = 5'd16;

  // One token as the back end sees it; the length fits in 32 bits output.
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
  } token_t;

  // Up to two tokens caused by one byte.
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } tok_pair_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      8'h24: single_kind = 6'd0;
      8'h28: single_kind = 6'd1;
      8'h29: single_kind = 6'd2;
      8'h7b: single_kind = 6'd3;
      8'h7d: single_kind = 6'd4;
      8'h5b: single_kind = 6'd5;
      8'h5d: single_kind = 6'd6;
      8'h3a: single_kind = 6'd7;
      8'h40: single_kind = 6'd8;
      8'h2c: single_kind = 6'd9;
      8'h3b: single_kind = 6'd10;
      8'h2e: single_kind = 6'd11;
      default: single_kind = 6'h3f;
    endcase
  endfunction

  function automatic logic [4:0] op_start(input logic [7:0] c);
    case (c)
      8'h2a: op_start = 5'd0;
      8'h2b: op_start = 5'd1;
      8'h2d: op_start = 5'd2;
      8'h21: op_start = 5'd3;
      8'h7c: op_start = 5'd4;
      8'h26: op_start = 5'd5;
      8'h5e: op_start = 5'd6;
      8'h7e: op_start = 5'd7;
      8'h3d: op_start = 5'd8;
      8'h2f: op_start = 5'd9;
      8'h25: op_start = 5'd10;
      8'h23: op_start = 5'd11;
      8'h3c: op_start = 5'd12;
      8'h3e: op_start = 5'd14;
      default: op_start = 5'h1f;
    endcase
  endfunction

  function automatic logic [5:0] op_lone(input logic [3:0] i);
    case (i)
      4'd0: op_lone = 6'd12;
      4'd1: op_lone = 6'd14;
      4'd2: op_lone = 6'd17;
      4'd3: op_lone = 6'd21;
      4'd4: op_lone = 6'd23;
      4'd5: op_lone = 6'd26;
      4'd6: op_lone = 6'd29;
      4'd7: op_lone = 6'd32;
      4'd8: op_lone = 6'd34;
      4'd9: op_lone = 6'd37;
      4'd10: op_lone = 6'd39;
      4'd11: op_lone = 6'd41;
      4'd12: op_lone = 6'd43;
      4'd13: op_lone = 6'd44;
      4'd14: op_lone = 6'd47;
      default: op_lone = 6'd48;
    endcase
  endfunction

  // Kind of the extended operator, or all ones when c does not extend it.
  function automatic logic [5:0] op_follow(input logic [3:0] i, input logic [7:0] c);
    logic eq, pl, mi, gt;
    eq = (c == 8'h3d);
    pl = (c == 8'h2b);
    mi = (c == 8'h2d);
    gt = (c == 8'h3e);
    op_follow = 6'h3f;
    case (i)
      4'd0: if (eq) op_follow = 6'd13;
      4'd1: if (pl) op_follow = 6'd15; else if (eq) op_follow = 6'd16;
      4'd2: if (mi) op_follow = 6'd18; else if (eq) op_follow = 6'd19;
            else if (gt) op_follow = 6'd20;
      4'd3: if (eq) op_follow = 6'd22;
      4'd4: if (c == 8'h7c) op_follow = 6'd24; else if (eq) op_follow = 6'd25;
      4'd5: if (c == 8'h26) op_follow = 6'd27; else if (eq) op_follow = 6'd28;
      4'd6: if (c == 8'h5e) op_follow = 6'd30; else if (eq) op_follow = 6'd31;
      4'd7: if (eq) op_follow = 6'd33;
      4'd8: if (eq) op_follow = 6'd35; else if (gt) op_follow = 6'd36;
      4'd9: if (eq) op_follow = 6'd38;
      4'd10: if (eq) op_follow = 6'd40;
      4'd11: if (c == 8'h23) op_follow = 6'd42;
      4'd12: if (eq) op_follow = 6'd46;
      4'd13: if (eq) op_follow = 6'd45;
      4'd14: if (eq) op_follow = 6'd50;
      default: if (eq) op_follow = 6'd49;
    endcase
  endfunction

endpackage

/* rtl/scl_front.sv */
// Front end of the lexer: classifies each byte against the current mode and
// produces up to two tokens. Depends on scl_pkg.
module scl_front #(
  parameter int OFFSET_BITS = 32,
  parameter int NEST_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         char_byte,
  output logic               emit,
  output scl_pkg::tok_pair_t pair
);

  logic [4:0]             lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, token_begin, token_begin_next;
  logic [NEST_BITS-1:0]   comment_depth, comment_depth_next;

  logic [OFFSET_BITS-1:0] p1, span;
  logic [31:0]            p32, p1_32, tb32, span32;
  logic                   again, is_alpha, is_digit;
  logic [5:0]             sk, fk;
  logic [4:0]             os;
  logic [3:0]             oi;
  scl_pkg::token_t        t0, t1;
  logic                   n0, n1;

  assign p1 = byte_offset + OFFSET_BITS'(1);
  assign span = byte_offset - token_begin;
  assign p32 = 32'(byte_offset);
  assign p1_32 = 32'(p1);
  assign tb32 = 32'(token_begin);
  assign span32 = 32'(span);
  assign is_alpha = (char_byte >= 8'h61 && char_byte <= 8'h7a) ||
                    (char_byte >= 8'h41 && char_byte <= 8'h5a) || char_byte == 8'h5f;
  assign is_digit = char_byte >= 8'h30 && char_byte <= 8'h39;
  assign sk = scl_pkg::single_kind(char_byte);
  assign os = scl_pkg::op_start(char_byte);
  assign oi = lex_mode[3:0];
  assign fk = scl_pkg::op_follow(oi, char_byte);

  always_comb begin
    lex_mode_next = lex_mode;
    token_begin_next = token_begin;
    comment_depth_next = comment_depth;
    again = 1'b0;
    n0 = 1'b0;
    n1 = 1'b0;
    t0 = '0;
    t1 = '0;
    if (lex_mode[4]) begin
      if (oi == 4'd9 && char_byte == 8'h2f) lex_mode_next = scl_pkg::M_LINE;
      else if (oi == 4'd9 && char_byte == 8'h2a) begin
        lex_mode_next = scl_pkg::M_BLOCK;
        comment_depth_next = NEST_BITS'(1);
      end else if (oi == 4'd12 && char_byte == 8'h3c) lex_mode_next = scl_pkg::M_OP + 5'd13;
      else if (oi == 4'd14 && char_byte == 8'h3e) lex_mode_next = scl_pkg::M_OP + 5'd15;
      else if (char_byte != 8'h00 && fk != 6'h3f) begin
        n0 = 1'b1;
        t0 = '{fk, tb32, (oi == 4'd13 || oi == 4'd15) ? 32'd3 : 32'd2, 1'b0};
        lex_mode_next = scl_pkg::M_IDLE;
      end else begin
        n0 = 1'b1;
        t0 = '{scl_pkg::op_lone(oi), tb32,
               (oi == 4'd13 || oi == 4'd15) ? 32'd2 : 32'd1, 1'b0};
        again = 1'b1;
      end
    end else begin
      case (lex_mode)
        scl_pkg::M_IDENT, scl_pkg::M_NUM: begin
          if (!(is_digit || (lex_mode == scl_pkg::M_IDENT && is_alpha))) begin
            n0 = 1'b1;
            t0 = '{(lex_mode == scl_pkg::M_IDENT) ? scl_pkg::K_IDENT : scl_pkg::K_NUM,
                   tb32, span32, 1'b0};
            again = 1'b1;
          end
        end
        scl_pkg::M_SQ, scl_pkg::M_DQ: begin
          if (char_byte == 8'h00) begin
            n0 = 1'b1;
            t0 = '{scl_pkg::K_UNTERM_LIT, tb32, span32, 1'b0};
            lex_mode_next = scl_pkg::M_IDLE;
          end else if (char_byte == 8'h5c) lex_mode_next = lex_mode + 5'd1;
          else if (char_byte == ((lex_mode == scl_pkg::M_SQ) ? 8'h27 : 8'h22)) begin
            n0 = 1'b1;
            t0 = '{(lex_mode == scl_pkg::M_SQ) ? scl_pkg::K_SQLIT : scl_pkg::K_DQLIT,
                   tb32, span32 + 32'd1, 1'b0};
            lex_mode_next = scl_pkg::M_IDLE;
          end else if (char_byte == 8'h0a) begin
            n0 = 1'b1;
            t0 = '{scl_pkg::K_LINE, p1_32, 32'd0, 1'b0};
          end
        end
        scl_pkg::M_SQ_ESC, scl_pkg::M_DQ_ESC: begin
          if (char_byte == 8'h00) begin
            n0 = 1'b1;
            t0 = '{scl_pkg::K_UNTERM_LIT, tb32, span32, 1'b0};
            lex_mode_next = scl_pkg::M_IDLE;
          end else begin
            if (char_byte == 8'h0a) begin
              n0 = 1'b1;
              t0 = '{scl_pkg::K_LINE, p1_32, 32'd0, 1'b0};
            end
            lex_mode_next = lex_mode - 5'd1;
          end
        end
        scl_pkg::M_LINE: begin
          if (char_byte == 8'h0a) begin
            n0 = 1'b1;
            t0 = '{scl_pkg::K_LINE, p1_32, 32'd0, 1'b0};
            lex_mode_next = scl_pkg::M_IDLE;
          end else if (char_byte == 8'h00) begin
            n0 = 1'b1;
            t0 = '{scl_pkg::K_END, p32, 32'd0, 1'b0};
            lex_mode_next = scl_pkg::M_IDLE;
          end
        end
        scl_pkg::M_BLOCK, scl_pkg::M_BSTAR, scl_pkg::M_BSLASH: begin
          if (lex_mode == scl_pkg::M_BSTAR && char_byte == 8'h2f) begin
            if (comment_depth != '0) comment_depth_next = comment_depth - NEST_BITS'(1);
            lex_mode_next = (comment_depth <= NEST_BITS'(1)) ? scl_pkg::M_IDLE
                                                             : scl_pkg::M_BLOCK;
          end else if (lex_mode == scl_pkg::M_BSLASH && char_byte == 8'h2a) begin
            if (comment_depth != '1) comment_depth_next = comment_depth + NEST_BITS'(1);
            lex_mode_next = scl_pkg::M_BLOCK;
          end else begin
            lex_mode_next = scl_pkg::M_BLOCK;
            if (char_byte == 8'h00) begin
              n0 = 1'b1;
              t0 = '{scl_pkg::K_UNTERM_COMMENT, tb32, span32, 1'b0};
              comment_depth_next = '0;
              lex_mode_next = scl_pkg::M_IDLE;
            end else if (char_byte == 8'h0a) begin
              n0 = 1'b1;
              t0 = '{scl_pkg::K_LINE, p1_32, 32'd0, 1'b0};
            end else if (char_byte == 8'h2a) lex_mode_next = scl_pkg::M_BSTAR;
            else if (char_byte == 8'h2f) lex_mode_next = scl_pkg::M_BSLASH;
          end
        end
        default: again = 1'b1;
      endcase
    end
    // Lex the byte afresh from idle; its token goes into the second slot when the first slot holds one.
    if (again) begin
      lex_mode_next = scl_pkg::M_IDLE;
      if (char_byte == 8'h00) begin
        n1 = 1'b1;
        t1 = '{scl_pkg::K_END, p32, 32'd0, 1'b0};
      end else if (char_byte == 8'h0a) begin
        n1 = 1'b1;
        t1 = '{scl_pkg::K_LINE, p1_32, 32'd0, 1'b0};
      end else if (char_byte == 8'h20 || char_byte == 8'h09) begin
        n1 = 1'b0;
      end else if (sk != 6'h3f) begin
        n1 = 1'b1;
        t1 = '{sk, p32, 32'd1, 1'b0};
      end else begin
        token_begin_next = byte_offset;
        if (os != 5'h1f) lex_mode_next = scl_pkg::M_OP + os;
        else if (char_byte == 8'h27) lex_mode_next = scl_pkg::M_SQ;
        else if (char_byte == 8'h22) lex_mode_next = scl_pkg::M_DQ;
        else if (is_alpha) lex_mode_next = scl_pkg::M_IDENT;
        else if (is_digit) lex_mode_next = scl_pkg::M_NUM;
        else begin
          n1 = 1'b1;
          t1 = '{scl_pkg::K_UNKNOWN, p32, 32'd1, 1'b0};
        end
      end
    end
  end

  // Pack so that the first token is always present when any is.
  always_comb begin
    pair = '0;
    emit = n0 | n1;
    pair.two = n0 & n1;
    if (n0) begin
      pair.first = t0;
      pair.first.last = ~n1;
      pair.second = t1;
      pair.second.last = 1'b1;
    end else begin
      pair.first = t1;
      pair.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= scl_pkg::M_IDLE;
      byte_offset <= '0;
      token_begin <= '0;
      comment_depth <= '0;
    end else if (take) begin
      lex_mode <= lex_mode_next;
      byte_offset <= p1;
      token_begin <= token_begin_next;
      comment_depth <= comment_depth_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (lex_mode == scl_pkg::M_BLOCK) |-> comment_depth != '0)
    else $error("block comment with zero depth");
  assert property (@(posedge clk) disable iff (rst)
    pair.two |-> emit && !pair.first.last && pair.second.last)
    else $error("token pair marks wrong");
  assert property (@(posedge clk) disable iff (rst)
    take |=> byte_offset == $past(byte_offset) + OFFSET_BITS'(1))
    else $error("offset did not advance");

endmodule

/* rtl/scl_queue.sv */
// Token queue between the front and back ends; takes one or two tokens per
// push and delivers one per pop. Depends on scl_pkg.
module scl_queue #(
  parameter int DEPTH_BITS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  scl_pkg::tok_pair_t wr_pair,
  output logic               room,
  input  logic               rd,
  output logic               avail,
  output scl_pkg::token_t    rd_tok
);

  localparam int DEPTH = 1 << DEPTH_BITS;

  scl_pkg::token_t         slots [DEPTH];
  logic [DEPTH_BITS-1:0]   wp, rp;
  logic [DEPTH_BITS:0]     count, count_next;

  // Keep room for a worst-case pair.
  assign room = count <= (DEPTH_BITS+1)'(DEPTH - 2);
  assign avail = count != '0;
  assign rd_tok = slots[rp];

  always_comb begin
    count_next = count;
    if (wr) count_next = count_next + (wr_pair.two ? (DEPTH_BITS+1)'(2) : (DEPTH_BITS+1)'(1));
    if (rd && avail) count_next = count_next - (DEPTH_BITS+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_pair.first;
      if (wr_pair.two) slots[wp + DEPTH_BITS'(1)] <= wr_pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + (wr_pair.two ? DEPTH_BITS'(2) : DEPTH_BITS'(1));
      if (rd && avail) rp <= rp + DEPTH_BITS'(1);
      count <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (DEPTH_BITS+1)'(DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) wr |-> room)
    else $error("write without room");
  assert property (@(posedge clk) disable iff (rst)
    (rd && avail && !wr) |=> count == $past(count) - (DEPTH_BITS+1)'(1))
    else $error("pop did not drain");

endmodule

/* rtl/source_code_lexer_core.sv */
// Top level of the source code lexer: byte classifier in front, token queue
// behind. Depends on scl_pkg, scl_front and scl_queue.
//
//   channel  handshake     payload
//   input    push / full   char_byte
//   result   pop / empty   token_kind, token_start, token_length, last_of_run
//
// One byte per cycle while full is low; the front-end mode logic is combinational.
// A byte yields zero to two tokens; the queue holds four, so full rises
// while fewer than two slots are free. The queue is registered: empty falls in
// the cycle after a byte that yields a token is taken. Reset clears the mode, offsets, nesting depth and the queue.
module source_code_lexer_core #(
  parameter int OFFSET_BITS = 32,
  parameter int NEST_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        pop,
  output logic        empty,
  output logic [5:0]  token_kind,
  output logic [31:0] token_start,
  output logic [31:0] token_length,
  output logic        last_of_run
);

  logic               take, emit, room, avail;
  scl_pkg::tok_pair_t pair;
  scl_pkg::token_t    head;

  assign full = ~room;
  assign take = push & room;
  assign empty = ~avail;

  scl_front #(.OFFSET_BITS(OFFSET_BITS), .NEST_BITS(NEST_BITS)) u_front (
    .clk(clk), .rst(rst), .take(take), .char_byte(char_byte),
    .emit(emit), .pair(pair)
  );

  scl_queue #(.DEPTH_BITS(2)) u_queue (
    .clk(clk), .rst(rst), .wr(take & emit), .wr_pair(pair), .room(room),
    .rd(pop), .avail(avail), .rd_tok(head)
  );

  assign token_kind = head.kind;
  assign token_start = head.start;
  assign token_length = head.length;
  assign last_of_run = head.last;

endmodule

/* sim/tb_source_code_lexer_core.sv */
// Testbench for source_code_lexer_core: drives source bytes through push/full,
// predicts tokens with a behavioural lexer model and checks them on pop/empty.
// Depends on scl_pkg and the lexer RTL.
`timescale 1ns / 100ps

module tb_source_code_lexer_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] C_STAR = 8'h2a;
  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_EQ = 8'h3d;
  localparam logic [7:0] C_LT = 8'h3c;
  localparam logic [7:0] C_GT = 8'h3e;
  localparam logic [7:0] C_NL = 8'h0a;
  localparam logic [7:0] C_SQ = 8'h27;
  localparam logic [7:0] C_DQ = 8'h22;
  localparam logic [7:0] C_BS = 8'h5c;
  localparam logic [7:0] C_EOF = 8'h00;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  char_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full, empty, last_of_run;
  logic [5:0]  token_kind;
  logic [31:0] token_start, token_length;

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  bit done_sending = 1'b0;

  always #2 clk = ~clk;

  source_code_lexer_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .pop(pop), .empty(empty), .token_kind(token_kind), .token_start(token_start),
    .token_length(token_length), .last_of_run(last_of_run)
  );

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  class token_scoreboard;
    scl_pkg::token_t pending[$];
    logic [4:0] mode;
    logic [31:0] offset, begin_at;
    logic [7:0] depth;

    function void clear();
      pending.delete();
      mode = scl_pkg::M_IDLE;
      offset = '0;
      begin_at = '0;
      depth = '0;
    endfunction

    function void add(input logic [5:0] k, input logic [31:0] s, input logic [31:0] l,
                      inout scl_pkg::token_t out[$]);
      scl_pkg::token_t t;
      t.kind = k;
      t.start = s;
      t.length = l;
      t.last = 1'b0;
      out.push_back(t);
    endfunction

    function bit is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // Kind of a single-character punctuation token, or all ones.
    function logic [5:0] lone_kind(input logic [7:0] c);
      case (c)
        "$": return 6'd0;  "(": return 6'd1;  ")": return 6'd2;  "{": return 6'd3;
        "}": return 6'd4;  "[": return 6'd5;  "]": return 6'd6;  ":": return 6'd7;
        "@": return 6'd8;  ",": return 6'd9;  ";": return 6'd10; ".": return 6'd11;
        default: return 6'h3f;
      endcase
    endfunction

    function int pend_index(input logic [7:0] c);
      case (c)
        "*": return 0;  "+": return 1;  "-": return 2;  "!": return 3;
        "|": return 4;  "&": return 5;  "^": return 6;  "~": return 7;
        "=": return 8;  "/": return 9;  "%": return 10; "#": return 11;
        "<": return 12; ">": return 14;
        default: return -1;
      endcase
    endfunction

    function logic [5:0] pend_alone(input int i);
      logic [5:0] tab[16] = '{12, 14, 17, 21, 23, 26, 29, 32, 34, 37, 39, 41, 43, 44,
                             47, 48};
      return tab[i];
    endfunction

    function logic [5:0] pend_ext(input int i, input logic [7:0] c);
      case (i)
        0: if (c == "=") return 6'd13;
        1: if (c == "+") return 6'd15; else if (c == "=") return 6'd16;
        2: if (c == "-") return 6'd18; else if (c == "=") return 6'd19;
           else if (c == ">") return 6'd20;
        3: if (c == "=") return 6'd22;
        4: if (c == "|") return 6'd24; else if (c == "=") return 6'd25;
        5: if (c == "&") return 6'd27; else if (c == "=") return 6'd28;
        6: if (c == "^") return 6'd30; else if (c == "=") return 6'd31;
        7: if (c == "=") return 6'd33;
        8: if (c == "=") return 6'd35; else if (c == ">") return 6'd36;
        9: if (c == "=") return 6'd38;
        10: if (c == "=") return 6'd40;
        11: if (c == "#") return 6'd42;
        12: if (c == "=") return 6'd46;
        13: if (c == "=") return 6'd45;
        14: if (c == "=") return 6'd50;
        15: if (c == "=") return 6'd49;
        default: ;
      endcase
      return 6'h3f;
    endfunction

    function void lex_idle(input logic [7:0] c, input logic [31:0] p,
                           inout scl_pkg::token_t out[$]);
      int k;
      mode = scl_pkg::M_IDLE;
      if (c == C_EOF) begin add(scl_pkg::K_END, p, 0, out); return; end
      if (c == " " || c == 8'h09) return;
      if (c == C_NL) begin add(scl_pkg::K_LINE, p + 1, 0, out); return; end
      if (lone_kind(c) != 6'h3f) begin add(lone_kind(c), p, 1, out); return; end
      begin_at = p;
      k = pend_index(c);
      if (k >= 0) mode = scl_pkg::M_OP + 5'(k);
      else if (c == C_SQ) mode = scl_pkg::M_SQ;
      else if (c == C_DQ) mode = scl_pkg::M_DQ;
      else if (is_alpha(c)) mode = scl_pkg::M_IDENT;
      else if (is_digit(c)) mode = scl_pkg::M_NUM;
      else add(scl_pkg::K_UNKNOWN, p, 1, out);
    endfunction

    function void lex_block(input logic [7:0] c, input logic [31:0] p,
                            inout scl_pkg::token_t out[$]);
      mode = scl_pkg::M_BLOCK;
      if (c == C_EOF) begin
        add(scl_pkg::K_UNTERM_COMMENT, begin_at, p - begin_at, out);
        depth = 0;
        mode = scl_pkg::M_IDLE;
      end else if (c == C_NL) add(scl_pkg::K_LINE, p + 1, 0, out);
      else if (c == C_STAR) mode = scl_pkg::M_BSTAR;
      else if (c == C_SLASH) mode = scl_pkg::M_BSLASH;
    endfunction

    // Note one accepted byte and queue the tokens it causes.
    function void note_byte(input logic [7:0] c);
      scl_pkg::token_t out[$];
      logic [31:0] p = offset;
      logic [31:0] span = offset - begin_at;
      bit relex = 1'b0;
      int idx;
      logic [5:0] k;
      case (mode)
        scl_pkg::M_IDLE: relex = 1'b1;
        scl_pkg::M_IDENT, scl_pkg::M_NUM: begin
          if (!(is_digit(c) || (mode == scl_pkg::M_IDENT && is_alpha(c)))) begin
            add(mode == scl_pkg::M_IDENT ? scl_pkg::K_IDENT : scl_pkg::K_NUM,
                begin_at, span, out);
            relex = 1'b1;
          end
        end
        scl_pkg::M_SQ, scl_pkg::M_DQ: begin
          if (c == C_EOF) begin
            add(scl_pkg::K_UNTERM_LIT, begin_at, span, out);
            mode = scl_pkg::M_IDLE;
          end else if (c == C_BS) mode = mode + 1;
          else if (c == (mode == scl_pkg::M_SQ ? C_SQ : C_DQ)) begin
            add(mode == scl_pkg::M_SQ ? scl_pkg::K_SQLIT : scl_pkg::K_DQLIT,
                begin_at, span + 1, out);
            mode = scl_pkg::M_IDLE;
          end else if (c == C_NL) add(scl_pkg::K_LINE, p + 1, 0, out);
        end
        scl_pkg::M_SQ_ESC, scl_pkg::M_DQ_ESC: begin
          if (c == C_EOF) begin
            add(scl_pkg::K_UNTERM_LIT, begin_at, span, out);
            mode = scl_pkg::M_IDLE;
          end else begin
            if (c == C_NL) add(scl_pkg::K_LINE, p + 1, 0, out);
            mode = mode - 1;
          end
        end
        scl_pkg::M_LINE: begin
          if (c == C_NL) begin
            add(scl_pkg::K_LINE, p + 1, 0, out);
            mode = scl_pkg::M_IDLE;
          end else if (c == C_EOF) begin
            add(scl_pkg::K_END, p, 0, out);
            mode = scl_pkg::M_IDLE;
          end
        end
        scl_pkg::M_BLOCK: lex_block(c, p, out);
        scl_pkg::M_BSTAR: begin
          if (c == C_SLASH) begin
            if (depth > 0) depth--;
            mode = (depth == 0) ? scl_pkg::M_IDLE : scl_pkg::M_BLOCK;
          end else lex_block(c, p, out);
        end
        scl_pkg::M_BSLASH: begin
          if (c == C_STAR) begin
            if (depth != 8'hff) depth++;
            mode = scl_pkg::M_BLOCK;
          end else lex_block(c, p, out);
        end
        default: begin
          idx = int'(mode - scl_pkg::M_OP);
          k = pend_ext(idx, c);
          if (idx == 9 && c == C_SLASH) mode = scl_pkg::M_LINE;
          else if (idx == 9 && c == C_STAR) begin mode = scl_pkg::M_BLOCK; depth = 1; end
          else if (idx == 12 && c == C_LT) mode = scl_pkg::M_OP + 5'd13;
          else if (idx == 14 && c == C_GT) mode = scl_pkg::M_OP + 5'd15;
          else if (c != C_EOF && k != 6'h3f) begin
            add(k, begin_at, (idx == 13 || idx == 15) ? 3 : 2, out);
            mode = scl_pkg::M_IDLE;
          end else begin
            add(pend_alone(idx), begin_at, (idx == 13 || idx == 15) ? 2 : 1, out);
            relex = 1'b1;
          end
        end
      endcase
      if (relex) lex_idle(c, p, out);
      offset = p + 1;
      if (out.size() > 0) out[out.size() - 1].last = 1'b1;
      foreach (out[i]) pending.push_back(out[i]);
    endfunction

    task check_token(input scl_pkg::token_t got);
      scl_pkg::token_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected token kind %0d", got.kind));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.start !== want.start)
        report($sformatf("start %0d, want %0d (kind %0d)", got.start, want.start, want.kind));
      if (got.length !== want.length)
        report($sformatf("length %0d, want %0d (kind %0d)", got.length, want.length,
                         want.kind));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b (kind %0d)", got.last, want.last, want.kind));
    endtask
  endclass

  token_scoreboard tokens = new();

  // Offer one byte; hold it until accepted. Push stays high for the next byte.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    char_byte <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    tokens.note_byte(c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Mostly well-formed fragments with random content, some raw noise.
  task automatic send_fragment();
    int n;
    case ($urandom_range(11))
      0: begin
        send_byte(pick("abcXYZ_q")); n = $urandom_range(5);
        repeat (n) send_byte(pick("az09_QM"));
      end
      1: begin n = $urandom_range(1, 5); repeat (n) send_byte(pick("0123456789")); end
      2: begin
        send_byte(pick("*+-!|&^~=/%#<>"));
        if ($urandom_range(1)) send_byte(pick("=+->|&^#<*"));
        if ($urandom_range(1)) send_byte(pick("=<> "));
      end
      3, 4: begin
        logic [7:0] q = $urandom_range(1) ? C_SQ : C_DQ;
        send_byte(q); n = $urandom_range(4);
        repeat (n) send_byte($urandom_range(3) == 0 ? pick("\\\n'\"") : pick("ab 1*"));
        if ($urandom_range(3) != 0) send_byte(q);
      end
      5: begin
        send_text("//"); n = $urandom_range(4);
        repeat (n) send_byte(pick("a*/ x"));
        send_byte($urandom_range(5) == 0 ? C_EOF : C_NL);
      end
      6: begin
        send_text("/*"); n = $urandom_range(6);
        repeat (n) send_byte(pick("a\n*/*/ x"));
        if ($urandom_range(3) == 0) send_text("/*x*/");
        send_text("*/");
        if ($urandom_range(1)) send_text("*/");
      end
      7: send_byte(pick(" \t\n$(){}[]:@,;."));
      8: send_byte($urandom_range(255));
      9: send_byte(C_EOF);
      default: send_byte(pick("a1+=<>/ \n"));
    endcase
  endtask

  // Receiver: pops at random unless held off.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      tokens.check_token('{token_kind, token_start, token_length, last_of_run});
    pop <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    tokens.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operators, literals, comments and several end-of-input cases.
    send_text("a_9 123 $()<<=>>=>=->*/");
    send_text("'a\\'b' \"x\\\n\" /*a/*b*/c*/ // z\n");
    send_byte(8'h80); send_byte(8'hff); send_byte(8'h0d);
    send_text("x1"); send_byte(C_EOF);
    send_text("'ab\\"); send_byte(C_EOF);
    send_text("/*/*"); send_byte(C_EOF);
    send_text("//q"); send_byte(C_EOF);
    send_text("<<"); send_byte(C_EOF);

    // Fill the queue with the receiver held off.
    hold_off = 1'b1;
    fork
      begin repeat (60) @(posedge clk); hold_off = 1'b0; end
      begin
        send_text("+ - * ; , . @ : ( ) { }");
        push <= 1'b0;
      end
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
      recv_idle = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
      n = 0;
      while (n < 55) begin
        send_fragment();
        n++;
      end
      for (int b = 0; b < 8; b++) begin
        send_byte(8'(1 << b)); send_byte(~8'(1 << b));
      end
    end
    send_byte(C_EOF);
    push <= 1'b0;

    while (tokens.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
